// File: hdl/bmbs_pkg.sv
package bmbs_pkg;

  // field widths fixed by the port list
  localparam int OP_W    = 3;
  localparam int IDX_W   = 10;
  localparam int POS_W   = 11;
  // widest map word index and bit offset over the legal parameter range
  localparam int WIDX_W  = 10;
  localparam int OFF_W   = 6;

  // request codes
  localparam logic [OP_W-1:0] OP_TEST = 3'd0;
  localparam logic [OP_W-1:0] OP_TSET = 3'd1;
  localparam logic [OP_W-1:0] OP_TCLR = 3'd2;
  localparam logic [OP_W-1:0] OP_FNS  = 3'd3;
  localparam logic [OP_W-1:0] OP_FFC  = 3'd4;

  // classified request, passed from front end to back end
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              imm;         // answer known without touching the map
    logic [WIDX_W-1:0] word_first;  // first map word to read
    logic [WIDX_W-1:0] word_last;   // last map word of a search
    logic [OFF_W-1:0]  off_first;   // bit offset in first word
    logic [OFF_W-1:0]  off_last;    // bit offset of last bit searched
    logic [POS_W-1:0]  base;        // bit number of bit 0 of first word
    logic [POS_W-1:0]  lim;         // saturated search limit
  } cmd_t;

endpackage

// File: hdl/bmbs_ram.sv
module bmbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/bmbs_front.sv
module bmbs_front #(
  parameter int WORD_BITS = 64,
  parameter int MAP_WORDS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bmbs_pkg::OP_W-1:0]   op,
  input  logic [bmbs_pkg::IDX_W-1:0]  bit_index,
  input  logic [bmbs_pkg::POS_W-1:0]  search_limit,
  output logic                        push,
  output bmbs_pkg::cmd_t              cmd,
  input  logic                        full
);

  localparam int POS_W      = bmbs_pkg::POS_W;
  localparam int IDX_W      = bmbs_pkg::IDX_W;
  localparam int OFF_W      = bmbs_pkg::OFF_W;
  localparam int WIDX_W     = bmbs_pkg::WIDX_W;
  localparam int TOTAL_BITS = WORD_BITS * MAP_WORDS;
  localparam int TOT_W      = $clog2(TOTAL_BITS + 1);
  localparam int CMP_W      = (TOT_W > POS_W) ? TOT_W : POS_W;
  // reciprocal of the word size; exact for all 11-bit dividends
  localparam int RCP_SH     = 22;
  localparam int RECIP      = ((1 << RCP_SH) + WORD_BITS - 1) / WORD_BITS;

  logic [CMP_W-1:0]  lim_ext;
  logic [CMP_W-1:0]  idx_ext;
  logic [POS_W-1:0]  lim_sat;
  logic [POS_W-1:0]  lim_m1;
  logic [31:0]       prod_idx;
  logic [31:0]       prod_end;

  logic              s1_valid;
  logic [2:0]        s1_op;
  logic [IDX_W-1:0]  s1_idx;
  logic [POS_W-1:0]  s1_lim;
  logic [POS_W-1:0]  s1_lm1;
  logic              s1_inside;
  logic [WIDX_W-1:0] s1_qi;
  logic [WIDX_W-1:0] s1_qe;

  logic [POS_W-1:0]  base_i;
  logic [POS_W-1:0]  base_e;
  logic [POS_W-1:0]  rem_i;
  logic [POS_W-1:0]  rem_e;
  logic              imm;

  // stage 1: saturate limit, word numbers by reciprocal multiply
  always_comb begin
    lim_ext  = CMP_W'(search_limit);
    idx_ext  = CMP_W'(bit_index);
    lim_sat  = (lim_ext > CMP_W'(TOTAL_BITS)) ? POS_W'(TOTAL_BITS) : search_limit;
    lim_m1   = lim_sat - POS_W'(1);
    prod_idx = 32'(bit_index) * 32'(RECIP);
    prod_end = 32'(lim_m1) * 32'(RECIP);
  end

  assign in_ready = !s1_valid || !full;
  assign push     = s1_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op     <= op;
      s1_idx    <= bit_index;
      s1_lim    <= lim_sat;
      s1_lm1    <= lim_m1;
      s1_inside <= idx_ext < CMP_W'(TOTAL_BITS);
      s1_qi     <= prod_idx[RCP_SH+WIDX_W-1:RCP_SH];
      s1_qe     <= prod_end[RCP_SH+WIDX_W-1:RCP_SH];
    end
  end

  // stage 2: bit offsets and the cases answered without a scan
  always_comb begin
    base_i = POS_W'(s1_qi * WORD_BITS);
    base_e = POS_W'(s1_qe * WORD_BITS);
    rem_i  = POS_W'(s1_idx) - base_i;
    rem_e  = s1_lm1 - base_e;
    case (s1_op)
      bmbs_pkg::OP_TEST,
      bmbs_pkg::OP_TSET,
      bmbs_pkg::OP_TCLR: imm = !s1_inside;
      bmbs_pkg::OP_FNS:  imm = POS_W'(s1_idx) >= s1_lim;
      bmbs_pkg::OP_FFC:  imm = s1_lim == '0;
      default:           imm = 1'b1;
    endcase
  end

  always_comb begin
    cmd.op        = s1_op;
    cmd.imm       = imm;
    cmd.word_last = s1_qe;
    cmd.off_last  = rem_e[OFF_W-1:0];
    cmd.lim       = s1_lim;
    if (s1_op == bmbs_pkg::OP_FFC) begin
      cmd.word_first = '0;
      cmd.off_first  = '0;
      cmd.base       = '0;
    end else begin
      cmd.word_first = s1_qi;
      cmd.off_first  = rem_i[OFF_W-1:0];
      cmd.base       = base_i;
    end
  end

endmodule

// File: hdl/bmbs_queue.sv
module bmbs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bmbs_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output bmbs_pkg::cmd_t head
);

  bmbs_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = entries[rd_ptr];

  // two-entry queue between classifier and map engine
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: hdl/bmbs_back.sv
module bmbs_back #(
  parameter int WORD_BITS = 64,
  parameter int MAP_WORDS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       empty,
  input  bmbs_pkg::cmd_t             head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       old_bit,
  output logic [bmbs_pkg::POS_W-1:0] found_position
);

  localparam int POS_W = bmbs_pkg::POS_W;
  localparam int AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW    = $clog2(WORD_BITS);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_TEST  = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [AW-1:0]        clr_cnt;
  bmbs_pkg::cmd_t       cur;
  logic [AW-1:0]        dword;
  logic [POS_W-1:0]     base;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [AW-1:0]        raddr;
  logic [WORD_BITS-1:0] rdata;

  logic                 out_free;
  logic [BW-1:0]        cur_off;
  logic                 cur_bit;
  logic [WORD_BITS-1:0] bit_sel;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] scan_mask;
  logic [WORD_BITS-1:0] hit;
  logic [WORD_BITS-1:0] low;
  logic [BW-1:0]        bitpos;
  logic                 is_first;
  logic                 is_last;
  logic [POS_W-1:0]     scan_pos;
  logic                 is_find;
  logic                 res_load;
  logic                 res_old;
  logic [POS_W-1:0]     res_pos;

  bmbs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == S_IDLE) && !empty && out_free;
  assign is_find  = (head.op == bmbs_pkg::OP_FNS) || (head.op == bmbs_pkg::OP_FFC);

  // single-bit access
  always_comb begin
    cur_off = cur.off_first[BW-1:0];
    cur_bit = rdata[cur_off];
    bit_sel = {{(WORD_BITS-1){1'b0}}, 1'b1} << cur_off;
  end

  // search window inside the current map word, lowest hit
  always_comb begin
    is_first = dword == cur.word_first[AW-1:0];
    is_last  = dword == cur.word_last[AW-1:0];
    cand     = (cur.op == bmbs_pkg::OP_FFC) ? ~rdata : rdata;
    for (int i = 0; i < WORD_BITS; i++) begin
      scan_mask[i] = (!is_first || (BW'(i) >= cur.off_first[BW-1:0])) &&
                     (!is_last  || (BW'(i) <= cur.off_last[BW-1:0]));
    end
    hit    = cand & scan_mask;
    low    = hit & (~hit + {{(WORD_BITS-1){1'b0}}, 1'b1});
    bitpos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low[i]) begin
        bitpos = bitpos | BW'(i);
      end
    end
    scan_pos = base + POS_W'(bitpos);
  end

  // sequencer: clearing pass, immediate answers, single-bit access, word-by-word scan
  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = clr_cnt;
    wdata      = '0;
    raddr      = head.word_first[AW-1:0];
    res_load   = 1'b0;
    res_old    = 1'b0;
    res_pos    = '0;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        if (clr_cnt == AW'(MAP_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) begin
          if (head.imm) begin
            res_load = 1'b1;
            res_pos  = is_find ? head.lim : '0;
          end else if (is_find) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_TEST;
          end
        end
      end
      S_TEST: begin
        res_load   = 1'b1;
        res_old    = cur_bit;
        waddr      = dword;
        state_next = S_IDLE;
        if (cur.op == bmbs_pkg::OP_TSET) begin
          we    = 1'b1;
          wdata = rdata | bit_sel;
        end else if (cur.op == bmbs_pkg::OP_TCLR) begin
          we    = 1'b1;
          wdata = rdata & ~bit_sel;
        end
      end
      S_SCAN: begin
        raddr = dword + AW'(1);
        if (|hit) begin
          res_load   = 1'b1;
          res_pos    = scan_pos;
          state_next = S_IDLE;
        end else if (is_last) begin
          res_load   = 1'b1;
          res_pos    = cur.lim;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request context and scan position
  always_ff @(posedge clk) begin
    if (pop) begin
      cur   <= head;
      dword <= head.word_first[AW-1:0];
      base  <= head.base;
    end else if (state == S_SCAN) begin
      dword <= dword + AW'(1);
      base  <= base + POS_W'(WORD_BITS);
    end
    if (res_load) begin
      old_bit        <= res_old;
      found_position <= res_pos;
    end
  end

`ifndef SYNTHESIS
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_CLEAR) || (state == S_TEST))
    else $error("map written outside clear pass or bit update");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !pop)
    else $error("request taken during clearing pass");

  a_pop_out_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> out_free)
    else $error("request started with result register occupied");

  a_found_below_lim: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && (|hit)) |-> (scan_pos < cur.lim))
    else $error("search hit at or past limit");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    res_load |=> out_valid && (state != S_TEST) && (state != S_SCAN))
    else $error("engine still busy after giving its result");
`endif

endmodule

// File: hdl/bitmap_bit_ops_and_search.sv
// Bitmap of WORD_BITS * MAP_WORDS bits with bit test/update and searches.
// Input channel (in_valid/in_ready): op, bit_index, search_limit. Output
// channel (out_valid/out_ready): old_bit, found_position, one word per request.
// A front end registers each request, saturates the limit and splits bit
// numbers into map word and offset; a two-entry queue feeds the back end,
// which holds the map in a single-port-write, registered-read RAM.
// The back end takes one request at a time: a test op reads its map word and
// writes it back for set/clear, a request answered without the map (unknown
// op, limit/offset out of range) is answered from the idle state, and a search
// reads map words in turn, one RAM read per cycle, until a hit or its last word.
// After reset the back end runs a clearing pass that zeroes all MAP_WORDS map
// words; requests are queued meanwhile (up to three held).
// The result register holds while out_ready is low; the front end keeps
// accepting until its stage and the queue are full.
module bitmap_bit_ops_and_search #(
  parameter int WORD_BITS = 64,
  parameter int MAP_WORDS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bmbs_pkg::OP_W-1:0]   op,
  input  logic [bmbs_pkg::IDX_W-1:0]  bit_index,
  input  logic [bmbs_pkg::POS_W-1:0]  search_limit,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        old_bit,
  output logic [bmbs_pkg::POS_W-1:0]  found_position
);

  logic           push;
  logic           full;
  logic           pop;
  logic           empty;
  bmbs_pkg::cmd_t push_cmd;
  bmbs_pkg::cmd_t head;

  bmbs_front #(
    .WORD_BITS (WORD_BITS),
    .MAP_WORDS (MAP_WORDS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .bit_index    (bit_index),
    .search_limit (search_limit),
    .push         (push),
    .cmd          (push_cmd),
    .full         (full)
  );

  bmbs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  bmbs_back #(
    .WORD_BITS (WORD_BITS),
    .MAP_WORDS (MAP_WORDS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .empty          (empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .old_bit        (old_bit),
    .found_position (found_position)
  );

endmodule
